// File: rtl/core/button_debounce_autorepeat_macros.svh
// Assertion macros for the button debounce and auto-repeat block.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge out of reset
`define BDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bda assertion failed: same-cycle implication");

// Next-cycle implication, checked on every clock edge out of reset
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bda assertion failed: next-cycle implication");

`else

`define BDA_ASSERT_NOW(label, clk, rst, ante, cons)
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/bda_pkg.sv
// Shared types, constants and codes for the button debounce and auto-repeat block.
package bda_pkg;

   // Countdown width and configuration register width
   localparam int COUNT_WIDTH = 12;
   localparam int CSR_WIDTH   = 12;
   localparam int CSR_IDX_W   = 2;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CSR_WIDTH-1:0]   csr_data_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_EN  = 2'd3;

   // Configuration reset values
   localparam csr_data_type DEBOUNCE_RST = 12'd20;
   localparam csr_data_type HOLD_RST     = 12'd400;
   localparam csr_data_type REPEAT_RST   = 12'd100;

   // Pin mask, both buttons released
   localparam logic [1:0] PINS_RELEASED = 2'b11;

   // Phase codes
   localparam logic [1:0] PH_DETECT = 2'd0;
   localparam logic [1:0] PH_VERIFY = 2'd1;
   localparam logic [1:0] PH_REPEAT = 2'd2;

   // Event kinds and combination code
   localparam logic [1:0] KIND_FIRST  = 2'd0;
   localparam logic [1:0] KIND_SECOND = 2'd1;
   localparam logic [1:0] KIND_BOTH   = 2'd2;
   localparam logic [1:0] COMBO_NONE  = 2'd0;
   localparam logic [1:0] COMBO_BOTH  = 2'd3;

   typedef struct packed {
      csr_data_type debounce_ticks;
      csr_data_type hold_ticks;
      csr_data_type repeat_ticks;
      logic         edge_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [1:0] combo_code;
   } rsp_type;

   typedef struct packed {
      logic       running;
      logic       armed;
      logic [1:0] phase;
   } status_type;

endpackage

// File: rtl/core/button_debounce_autorepeat.sv
// Two-button debounce with hold and auto-repeat events.
// A request is registered on acceptance; an event it raises then waits for room in the
// output register, which stalls requests. The state update is a single decrement/compare.
// Throughput: one request per cycle while no event waits for output register room.
// Reset (synchronous, active high): timer stopped, armed, detect phase, pins
// taken as released, registers back to 20/400/100 and edges disabled.
`include "button_debounce_autorepeat_macros.svh"

module button_debounce_autorepeat (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_ms_tick,
   input  logic [1:0]                     req_pin_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_event_kind,
   output logic [1:0]                     rsp_combo_code,
   input  logic                           csr_write,
   input  logic [bda_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bda_pkg::CSR_WIDTH-1:0]  csr_data
);

   bda_pkg::cfg_type    cfg;
   bda_pkg::rsp_type    step_rsp;
   bda_pkg::rsp_type    out_rsp;
   bda_pkg::status_type status;

   logic       in_valid_ff, in_valid_in;
   logic       tick_ff;
   logic [1:0] pins_ff;
   logic       hit;
   logic       load_ready;
   logic       advance;
   logic       req_fire;
   logic       combo_ok;

   bda_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // A registered request retires unless its event has no room
   assign advance   = in_valid_ff & (~hit | load_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tick_ff <= req_ms_tick;
         pins_ff <= req_pin_levels;
      end
   end

   bda_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (advance),
      .ms_tick    (tick_ff),
      .pin_levels (pins_ff),
      .hit        (hit),
      .rsp        (step_rsp),
      .status     (status)
   );

   bda_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance & hit),
      .load_data  (step_rsp),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (out_rsp)
   );

   assign rsp_event_kind = out_rsp.event_kind;
   assign rsp_combo_code = out_rsp.combo_code;

   // Combination code set exactly for the both-pressed kind
   assign combo_ok = ((rsp_combo_code == bda_pkg::COMBO_BOTH)
                      == (rsp_event_kind == bda_pkg::KIND_BOTH));

   // Combination code tracks the both-pressed kind
   `BDA_ASSERT_NOW(a_combo_matches_kind, clock, reset, rsp_valid, combo_ok)
   // Disarmed only while a debounce countdown runs
   `BDA_ASSERT_NOW(a_disarmed_running, clock, reset, !status.armed, status.running)
   // An emitted event always leaves the detect phase
   `BDA_ASSERT_NEXT(a_event_leaves_detect, clock, reset, (advance && hit), (status.phase != bda_pkg::PH_DETECT))

endmodule

// File: rtl/core/bda_csr.sv
// Configuration registers of the button debounce and auto-repeat block.
module bda_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bda_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bda_pkg::CSR_WIDTH-1:0]     csr_data,
   output bda_pkg::cfg_type                  cfg
);

   bda_pkg::cfg_type cfg_ff;
   bda_pkg::cfg_type cfg_in;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bda_pkg::CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_data;
            bda_pkg::CSR_HOLD:     cfg_in.hold_ticks     = csr_data;
            bda_pkg::CSR_REPEAT:   cfg_in.repeat_ticks   = csr_data;
            bda_pkg::CSR_EDGE_EN:  cfg_in.edge_enable    = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= bda_pkg::DEBOUNCE_RST;
         cfg_ff.hold_ticks     <= bda_pkg::HOLD_RST;
         cfg_ff.repeat_ticks   <= bda_pkg::REPEAT_RST;
         cfg_ff.edge_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/bda_timer.sv
// Edge detect, debounce countdown and auto-repeat state for one request per cycle while step is high.
module bda_timer (
   input  logic                   clock,
   input  logic                   reset,
   input  bda_pkg::cfg_type       cfg,
   input  logic                   step,
   input  logic                   ms_tick,
   input  logic [1:0]             pin_levels,
   output logic                   hit,
   output bda_pkg::rsp_type       rsp,
   output bda_pkg::status_type    status
);

   logic [1:0]          phase_ff, phase_in;
   bda_pkg::count_type  count_ff, count_in;
   logic                running_ff, running_in;
   logic [1:0]          prev_ff, prev_in;
   logic                armed_ff, armed_in;

   logic [1:0] falling;
   logic [1:0] pressed;
   logic       edge_go;
   logic       expire;

   // Edge qualification and expiry
   assign falling = prev_ff & ~pin_levels;
   assign pressed = ~pin_levels;
   assign edge_go = cfg.edge_enable & armed_ff & (|falling);
   assign expire  = ~edge_go & running_ff & ms_tick
                    & (count_ff <= bda_pkg::count_type'(1));
   assign hit     = expire & (|pressed);

   // Result fields
   always_comb begin
      case (pressed)
         2'b01:   rsp.event_kind = bda_pkg::KIND_FIRST;
         2'b10:   rsp.event_kind = bda_pkg::KIND_SECOND;
         default: rsp.event_kind = bda_pkg::KIND_BOTH;
      endcase
      rsp.combo_code = (pressed == bda_pkg::PINS_RELEASED) ? bda_pkg::COMBO_BOTH
                                                           : bda_pkg::COMBO_NONE;
   end

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      running_in = running_ff;
      prev_in    = prev_ff;
      armed_in   = armed_ff;
      if (step) begin
         prev_in = pin_levels;
         if (edge_go) begin
            armed_in   = 1'b0;
            phase_in   = bda_pkg::PH_DETECT;
            count_in   = bda_pkg::count_type'(cfg.debounce_ticks);
            running_in = 1'b1;
         end else if (running_ff && ms_tick) begin
            if (!expire) begin
               count_in = count_ff - bda_pkg::count_type'(1);
            end else begin
               count_in = '0;
               armed_in = 1'b1;
               if (!hit) begin
                  running_in = 1'b0;
               end else begin
                  unique case (phase_ff)
                     bda_pkg::PH_DETECT: begin
                        count_in = bda_pkg::count_type'(cfg.hold_ticks);
                        phase_in = bda_pkg::PH_VERIFY;
                     end
                     default: begin
                        count_in = bda_pkg::count_type'(cfg.repeat_ticks);
                        phase_in = bda_pkg::PH_REPEAT;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bda_pkg::PH_DETECT;
         count_ff   <= '0;
         running_ff <= 1'b0;
         prev_ff    <= bda_pkg::PINS_RELEASED;
         armed_ff   <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         prev_ff    <= prev_in;
         armed_ff   <= armed_in;
      end
   end

   assign status.running = running_ff;
   assign status.armed   = armed_ff;
   assign status.phase   = phase_ff;

endmodule

// File: rtl/core/bda_rsp_reg.sv
// Result output register with valid/ready handshake.
module bda_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bda_pkg::rsp_type   load_data,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bda_pkg::rsp_type   rsp_data
);

   logic             valid_ff, valid_in;
   bda_pkg::rsp_type data_ff, data_in;

   // Slot frees when empty or drained this cycle
   assign load_ready = ~valid_ff | rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: bench/tb_button_debounce_autorepeat.sv
// Testbench for the two-button debounce and auto-repeat block.
`timescale 1ns / 100ps

module tb_button_debounce_autorepeat;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_PAD   = 8;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_ms_tick;
   logic [1:0]                    req_pin_levels;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_event_kind;
   logic [1:0]                    rsp_combo_code;
   logic                          csr_write;
   logic [bda_pkg::CSR_IDX_W-1:0] csr_index;
   bda_pkg::csr_data_type         csr_data;

   // Predictor state and its copy of the registers
   bda_pkg::cfg_type    timing_cfg;
   logic [1:0]          key_phase;
   bda_pkg::count_type  countdown;
   logic                timer_on;
   logic                armed;
   logic [1:0]          last_pins;

   bda_pkg::rsp_type    expected_events[$];
   bda_pkg::rsp_type    got_event;
   bda_pkg::rsp_type    want_event;

   int         failures;
   int         requests_sent;
   int         events_checked;
   int         settings_used;
   int         cycle_count;
   bit         no_idle;

   button_debounce_autorepeat uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ms_tick    (req_ms_tick),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_combo_code (rsp_combo_code),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 23);
   end

   // One debounce step for an accepted request; queues the event it raises
   function automatic void predict_debounce(input logic tick, input logic [1:0] pins);
      logic [1:0]       falling;
      logic [1:0]       pressed;
      bda_pkg::rsp_type ev;
      falling   = last_pins & ~pins;
      last_pins = pins;
      if (timing_cfg.edge_enable && armed && falling != 2'b00) begin
         // accepted edge restarts debounce, the tick of this step is dropped
         armed     = 1'b0;
         key_phase = bda_pkg::PH_DETECT;
         countdown = timing_cfg.debounce_ticks;
         timer_on  = 1'b1;
      end else if (timer_on && tick) begin
         if (countdown > 1) begin
            countdown = countdown - 1'b1;
         end else begin
            pressed   = ~pins;
            countdown = '0;
            armed     = 1'b1;
            if (pressed == 2'b00) begin
               timer_on = 1'b0;
            end else begin
               case (pressed)
                  2'b01:   ev.event_kind = bda_pkg::KIND_FIRST;
                  2'b10:   ev.event_kind = bda_pkg::KIND_SECOND;
                  default: ev.event_kind = bda_pkg::KIND_BOTH;
               endcase
               ev.combo_code = (pressed == 2'b11) ? bda_pkg::COMBO_BOTH
                                                  : bda_pkg::COMBO_NONE;
               expected_events.push_back(ev);
               if (key_phase == bda_pkg::PH_DETECT) begin
                  countdown = timing_cfg.hold_ticks;
                  key_phase = bda_pkg::PH_VERIFY;
               end else begin
                  countdown = timing_cfg.repeat_ticks;
                  key_phase = bda_pkg::PH_REPEAT;
               end
            end
         end
      end
   endfunction

   // Predictor update and event checker
   always @(posedge clock) begin
      if (reset) begin
         timing_cfg.debounce_ticks = bda_pkg::DEBOUNCE_RST;
         timing_cfg.hold_ticks     = bda_pkg::HOLD_RST;
         timing_cfg.repeat_ticks   = bda_pkg::REPEAT_RST;
         timing_cfg.edge_enable    = 1'b0;
         key_phase = bda_pkg::PH_DETECT;
         countdown = '0;
         timer_on  = 1'b0;
         armed     = 1'b1;
         last_pins = bda_pkg::PINS_RELEASED;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_event.event_kind = rsp_event_kind;
            got_event.combo_code = rsp_combo_code;
            events_checked++;
            if (expected_events.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected event: kind=%0d combo=%0d",
                           got_event.event_kind, got_event.combo_code);
            end else begin
               want_event = expected_events.pop_front();
               if (got_event.event_kind !== want_event.event_kind ||
                   got_event.combo_code !== want_event.combo_code) begin
                  failures++;
                  if (failures <= 10)
                     $display("event %0d: expected kind=%0d combo=%0d, got kind=%0d combo=%0d",
                              events_checked, want_event.event_kind, want_event.combo_code,
                              got_event.event_kind, got_event.combo_code);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               bda_pkg::CSR_DEBOUNCE: timing_cfg.debounce_ticks = csr_data;
               bda_pkg::CSR_HOLD:     timing_cfg.hold_ticks     = csr_data;
               bda_pkg::CSR_REPEAT:   timing_cfg.repeat_ticks   = csr_data;
               bda_pkg::CSR_EDGE_EN:  timing_cfg.edge_enable    = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            requests_sent++;
            predict_debounce(req_ms_tick, req_pin_levels);
         end
      end
   end

   // Send one request and hold it until accepted; maybe idle afterwards
   task automatic send_request(input logic tick, input logic [1:0] pins);
      req_valid      <= 1'b1;
      req_ms_tick    <= tick;
      req_pin_levels <= pins;
      do @(posedge clock); while (!req_ready);
      if (!no_idle && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected event has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   // Write all four registers while the block is quiet
   task automatic program_timing(input bda_pkg::csr_data_type deb,
                                 input bda_pkg::csr_data_type hold,
                                 input bda_pkg::csr_data_type rep, input logic en);
      wait_for_drain();
      repeat (DRAIN_PAD) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= bda_pkg::CSR_DEBOUNCE;
      csr_data  <= deb;
      @(posedge clock);
      csr_index <= bda_pkg::CSR_HOLD;
      csr_data  <= hold;
      @(posedge clock);
      csr_index <= bda_pkg::CSR_REPEAT;
      csr_data  <= rep;
      @(posedge clock);
      csr_index <= bda_pkg::CSR_EDGE_EN;
      csr_data  <= bda_pkg::csr_data_type'(en);
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // Reset defaults: edges are disabled, so nothing starts
   task automatic test_edges_blocked();
      send_request(1'b1, 2'b00);
      send_request(1'b1, 2'b11);
      send_request(1'b0, 2'b10);
      send_request(1'b1, 2'b11);
   endtask

   // First button: edge with tick, hold event, repeats, release stops the timer
   task automatic test_hold_and_repeat();
      program_timing(12'd1, 12'd2, 12'd1, 1'b1);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b10);
      send_request(1'b0, 2'b10);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b11);
   endtask

   // Both buttons; the later edge lands while disarmed and is dropped
   task automatic test_combo_and_disarm();
      send_request(1'b0, 2'b01);
      send_request(1'b0, 2'b00);
      send_request(1'b1, 2'b00);
      send_request(1'b1, 2'b00);
      send_request(1'b1, 2'b00);
      send_request(1'b1, 2'b11);
   endtask

   // Debounce count of zero expires on the first tick
   task automatic test_zero_count();
      program_timing(12'd0, 12'd3, 12'd4095, 1'b1);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b10);
      send_request(1'b1, 2'b11);
      send_request(1'b1, 2'b11);
      send_request(1'b1, 2'b11);
   endtask

   // Full-scale debounce count: a held press raises nothing for many ticks
   task automatic test_full_scale();
      int i;
      program_timing(12'd4095, 12'd4095, 12'd1, 1'b1);
      send_request(1'b0, 2'b11);
      send_request(1'b0, 2'b01);
      for (i = 0; i < 40; i++)
         send_request(1'b1, 2'b01);
      send_request(1'b1, 2'b11);
      send_request(1'b1, 2'b11);
   endtask

   // Press/hold/release sequences with random content, plus noise
   task automatic test_random_traffic(input int target);
      int         sent;
      int         i;
      int         hold_len;
      logic [1:0] down;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 10) begin
            send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            sent++;
         end else begin
            case ($urandom_range(0, 2))
               0:       down = 2'b10;
               1:       down = 2'b01;
               default: down = 2'b00;
            endcase
            // contact bounce before the press settles
            if ($urandom_range(99) < 30) begin
               repeat ($urandom_range(1, 3)) begin
                  send_request(1'b0, 2'($urandom_range(0, 3)));
                  sent++;
               end
            end
            hold_len = $urandom_range(1, 30);
            for (i = 0; i < hold_len; i++) begin
               if ($urandom_range(99) < 5)
                  down = 2'($urandom_range(0, 2));
               send_request($urandom_range(99) < 60, down);
            end
            sent += hold_len;
            hold_len = $urandom_range(1, 12);
            for (i = 0; i < hold_len; i++)
               send_request($urandom_range(99) < 60, 2'b11);
            sent += hold_len;
         end
         if ($urandom_range(99) < 3)
            wait_for_drain();
      end
   endtask

   initial begin
      int round;
      failures       = 0;
      requests_sent  = 0;
      events_checked = 0;
      settings_used  = 0;
      cycle_count    = 0;
      no_idle        = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_ms_tick    <= 1'b0;
      req_pin_levels <= bda_pkg::PINS_RELEASED;
      csr_write      <= 1'b0;
      csr_index      <= bda_pkg::CSR_DEBOUNCE;
      csr_data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edges_blocked();
      test_hold_and_repeat();
      test_combo_and_disarm();
      test_zero_count();

      // Random rounds with short counts so events come often
      for (round = 0; round < 5; round++) begin
         program_timing(bda_pkg::csr_data_type'($urandom_range(1, 6)),
                        bda_pkg::csr_data_type'($urandom_range(1, 10)),
                        bda_pkg::csr_data_type'($urandom_range(1, 5)),
                        (round == 4) ? 1'($urandom_range(0, 1)) : 1'b1);
         no_idle = (round == 2);
         test_random_traffic(300);
         if (round == 1)
            wait_for_drain();
      end
      no_idle = 1'b0;

      test_full_scale();

      wait_for_drain();
      repeat (DRAIN_PAD) @(posedge clock);
      if (expected_events.size() != 0) begin
         failures += expected_events.size();
         $display("%0d expected events never came out", expected_events.size());
      end

      $display("Ran %0d requests and checked %0d events over %0d register settings,",
               requests_sent, events_checked, settings_used);
      $display("counts of 0, small and full scale, single and combined presses, bounce, stalls.");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bda_pkg.sv
rtl/core/bda_csr.sv
rtl/core/bda_timer.sv
rtl/core/bda_rsp_reg.sv
rtl/core/button_debounce_autorepeat.sv
bench/tb_button_debounce_autorepeat.sv
